>>> hdl/shp_pkg.sv
// Shared types and constants for the 3x3 sharpen stream block.
// No dependencies; every other file in hdl/ except shp_ram imports this package.
package shp_pkg;

  // Configuration register map
  localparam int CFG_IW = 2;
  localparam int CFG_DW = 12;

  localparam logic [CFG_IW-1:0] REG_FRAME_WIDTH   = 2'd0;
  localparam logic [CFG_IW-1:0] REG_FRAME_HEIGHT  = 2'd1;
  localparam logic [CFG_IW-1:0] REG_CHANNEL_COUNT = 2'd2;

  localparam int FW_W = 11;
  localparam int FH_W = 12;
  localparam int CC_W = 3;

  localparam logic [FW_W-1:0] FRAME_WIDTH_RST   = 11'd640;
  localparam logic [FH_W-1:0] FRAME_HEIGHT_RST  = 12'd480;
  localparam logic [CC_W-1:0] CHANNEL_COUNT_RST = 3'd3;

  // Smallest frame dimension and largest row count
  localparam int MIN_DIM  = 3;
  localparam int MAX_ROWS = 4095;

  localparam int SAMPLE_W = 8;

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample;
    logic                frame_start;
  } shp_in_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] sharpened;
    logic                last_of_run;
    logic                last_of_frame;
  } shp_out_t;

  // Per-item position flags handed from the position counters to the datapath
  typedef struct packed {
    logic emits;        // row above exists, so the item produces a result
    logic two_out;      // last row: extra zero border result follows
    logic border;       // result row is first row, or column is first/last
    logic has_right;    // right neighbor lies inside the row
    logic last_sample;  // final sample of the frame
  } shp_flags_t;

endpackage

>>> hdl/sharpen_3x3_stream.sv
// Top level of the streaming 3x3 Laplacian sharpen block.
// Depends on shp_pkg, shp_ram, shp_pos and shp_kernel.
//
// Usage:
//   Input channel (in_valid/in_ready/in_data) takes one 8-bit sample per
//   item in raster order, channels interleaved per pixel. Set
//   in_data.frame_start on the first sample of every frame; it clears the
//   column, channel and row positions.
//   Output channel (out_valid/out_ready/out_data) gives the sharpened value
//   for row r-1 while row r arrives. Row 0 gives no result; rows 1..H-2 give
//   one result per item; the last row gives two per item (row H-2, then the
//   zero border of row H-1). last_of_run flags the final result of an item,
//   last_of_frame the final result of the frame.
//   Results: an accepted item is held in the work stage, and its result
//   goes from there into the output register. Throughput: one item per cycle
//   while out_ready is high; the single output register slows the last row.
//   The line stores are block RAMs read at accept time: one read of row r-2
//   and two reads of row r-1 (center and right neighbor) per item.
//   Reset loads the default geometry (640x480, 3 channels) and clears the
//   positions; line stores are not cleared, so start each frame with
//   frame_start. When out_ready is low the result holds, an empty work stage
//   still takes one further item and in_ready drops while it waits to load.
//   Write cfg_* only while the block is idle.
module sharpen_3x3_stream #(
  parameter int MAX_WIDTH    = 1024,
  parameter int MAX_CHANNELS = 4
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  shp_pkg::shp_in_t            in_data,
  output logic                        out_valid,
  input  logic                        out_ready,
  output shp_pkg::shp_out_t           out_data,
  input  logic                        cfg_wr_en,
  input  logic [shp_pkg::CFG_IW-1:0]  cfg_index,
  input  logic [shp_pkg::CFG_DW-1:0]  cfg_wdata
);
  import shp_pkg::*;

  localparam int CW    = $clog2(MAX_WIDTH + 1);
  localparam int CNW   = $clog2(MAX_CHANNELS + 1);
  localparam int CHW   = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int DEPTH = MAX_WIDTH * MAX_CHANNELS;
  localparam int AW    = $clog2(DEPTH);

  // ---------------------------------------------------------------------
  // Configuration registers and clamping
  // ---------------------------------------------------------------------
  logic [FW_W-1:0] frame_width_r;
  logic [FH_W-1:0] frame_height_r;
  logic [CC_W-1:0] channel_count_r;
  logic [CW-1:0]   w_eff;
  logic [FH_W-1:0] h_eff;
  logic [CNW-1:0]  ch_eff;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r   <= FRAME_WIDTH_RST;
      frame_height_r  <= FRAME_HEIGHT_RST;
      channel_count_r <= CHANNEL_COUNT_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_FRAME_WIDTH:   frame_width_r   <= cfg_wdata[FW_W-1:0];
        REG_FRAME_HEIGHT:  frame_height_r  <= cfg_wdata[FH_W-1:0];
        REG_CHANNEL_COUNT: channel_count_r <= cfg_wdata[CC_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp width to 3..MAX_WIDTH, height to 3..4095, channels to 1..MAX_CHANNELS
  always_comb begin
    if (int'(frame_width_r) < MIN_DIM) begin
      w_eff = CW'(MIN_DIM);
    end else if (int'(frame_width_r) > MAX_WIDTH) begin
      w_eff = CW'(MAX_WIDTH);
    end else begin
      w_eff = CW'(frame_width_r);
    end

    if (int'(frame_height_r) < MIN_DIM) begin
      h_eff = FH_W'(MIN_DIM);
    end else if (int'(frame_height_r) > MAX_ROWS) begin
      h_eff = FH_W'(MAX_ROWS);
    end else begin
      h_eff = frame_height_r;
    end

    if (channel_count_r == '0) begin
      ch_eff = CNW'(1);
    end else if (int'(channel_count_r) > MAX_CHANNELS) begin
      ch_eff = CNW'(MAX_CHANNELS);
    end else begin
      ch_eff = CNW'(channel_count_r);
    end
  end

  // ---------------------------------------------------------------------
  // Accept stage: positions, addresses, line store reads
  // ---------------------------------------------------------------------
  logic            in_accept;
  logic [AW-1:0]   rd_addr;
  logic [AW-1:0]   rd_addr_right;
  logic [CHW-1:0]  rd_chan;
  shp_flags_t      rd_flags;

  assign in_accept = in_valid && in_ready;

  shp_pos #(
    .MAX_WIDTH    (MAX_WIDTH),
    .MAX_CHANNELS (MAX_CHANNELS)
  ) u_pos (
    .clk         (clk),
    .rst_n       (rst_n),
    .advance     (in_accept),
    .frame_start (in_data.frame_start),
    .w_eff       (w_eff),
    .h_eff       (h_eff),
    .ch_eff      (ch_eff),
    .addr        (rd_addr),
    .addr_right  (rd_addr_right),
    .chan        (rd_chan),
    .flags       (rd_flags)
  );

  // Work stage registers
  logic                s1_valid_r, s1_valid_nxt;
  logic                s1_phase_r, s1_phase_nxt;  // 1: border result of last row pending
  logic [AW-1:0]       s1_addr_r;
  logic [AW-1:0]       s1_addr_right_r;
  logic [CHW-1:0]      s1_chan_r;
  shp_flags_t          s1_flags_r;
  logic [SAMPLE_W-1:0] s1_sample_r;

  // Last line store write, forwarded to a read issued at the same edge
  logic                wr_vld_r;
  logic [AW-1:0]       wr_addr_r;
  logic [SAMPLE_W-1:0] wr_new_r;
  logic [SAMPLE_W-1:0] wr_old_r;

  // Previous pixel of row r-1, per channel
  logic [SAMPLE_W-1:0] win_r [MAX_CHANNELS];

  logic                mem_we;
  logic [SAMPLE_W-1:0] older_q, newer_c_q, newer_r_q;
  logic [SAMPLE_W-1:0] center, left, right, up;
  logic                hit_c, hit_r;

  // Row r-2
  shp_ram #(.WIDTH(SAMPLE_W), .DEPTH(DEPTH)) u_older (
    .clk   (clk),
    .we    (mem_we),
    .waddr (s1_addr_r),
    .wdata (center),
    .re    (in_accept),
    .raddr (rd_addr),
    .rdata (older_q)
  );

  // Row r-1, center read port
  shp_ram #(.WIDTH(SAMPLE_W), .DEPTH(DEPTH)) u_newer_c (
    .clk   (clk),
    .we    (mem_we),
    .waddr (s1_addr_r),
    .wdata (s1_sample_r),
    .re    (in_accept),
    .raddr (rd_addr),
    .rdata (newer_c_q)
  );

  // Row r-1, right neighbor read port (same contents as the center copy)
  shp_ram #(.WIDTH(SAMPLE_W), .DEPTH(DEPTH)) u_newer_r (
    .clk   (clk),
    .we    (mem_we),
    .waddr (s1_addr_r),
    .wdata (s1_sample_r),
    .re    (in_accept),
    .raddr (rd_addr_right),
    .rdata (newer_r_q)
  );

  // ---------------------------------------------------------------------
  // Work stage: neighbor selection and kernel
  // ---------------------------------------------------------------------
  logic [SAMPLE_W-1:0] kern_val;

  always_comb begin
    hit_c  = wr_vld_r && (wr_addr_r == s1_addr_r);
    hit_r  = wr_vld_r && (wr_addr_r == s1_addr_right_r);
    center = hit_c ? wr_new_r : newer_c_q;
    up     = hit_c ? wr_old_r : older_q;
    left   = win_r[s1_chan_r];
    if (s1_flags_r.has_right) begin
      right = hit_r ? wr_new_r : newer_r_q;
    end else begin
      right = '0;
    end
  end

  shp_kernel u_kernel (
    .center    (center),
    .left      (left),
    .right     (right),
    .up        (up),
    .down      (s1_sample_r),
    .border    (s1_flags_r.border),
    .sharpened (kern_val)
  );

  // ---------------------------------------------------------------------
  // Handshake and output register
  // ---------------------------------------------------------------------
  logic     out_valid_r, out_valid_nxt;
  shp_out_t out_data_r, out_data_nxt;
  logic     out_free;
  logic     out_load;
  logic     s1_done;

  always_comb begin
    out_free = !out_valid_r || out_ready;
    out_load = s1_valid_r && s1_flags_r.emits && out_free;
    // Item leaves once its final result is loaded, or at once on row 0
    s1_done  = s1_valid_r &&
               (!s1_flags_r.emits ||
                (out_free && (s1_phase_r || !s1_flags_r.two_out)));
    // Update line stores once per item, on its first move
    mem_we   = s1_valid_r && !s1_phase_r && (!s1_flags_r.emits || out_free);
    in_ready = !s1_valid_r || s1_done;

    s1_valid_nxt = in_accept ? 1'b1 : (s1_done ? 1'b0 : s1_valid_r);
    if (in_accept || s1_done) begin
      s1_phase_nxt = 1'b0;
    end else if (out_load && s1_flags_r.two_out) begin
      s1_phase_nxt = 1'b1;
    end else begin
      s1_phase_nxt = s1_phase_r;
    end

    out_valid_nxt = out_load || (out_valid_r && !out_ready);
    if (s1_phase_r) begin
      out_data_nxt.sharpened     = '0;
      out_data_nxt.last_of_run   = 1'b1;
      out_data_nxt.last_of_frame = s1_flags_r.last_sample;
    end else begin
      out_data_nxt.sharpened     = kern_val;
      out_data_nxt.last_of_run   = !s1_flags_r.two_out;
      out_data_nxt.last_of_frame = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s1_phase_r  <= 1'b0;
      out_valid_r <= 1'b0;
      wr_vld_r    <= 1'b0;
      for (int i = 0; i < MAX_CHANNELS; i++) begin
        win_r[i] <= '0;
      end
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      s1_phase_r  <= s1_phase_nxt;
      out_valid_r <= out_valid_nxt;
      if (mem_we) begin
        wr_vld_r          <= 1'b1;
        win_r[s1_chan_r]  <= center;
      end
    end
  end

  // Payload registers: hold unless loaded
  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_addr_r       <= rd_addr;
      s1_addr_right_r <= rd_addr_right;
      s1_chan_r       <= rd_chan;
      s1_flags_r      <= rd_flags;
      s1_sample_r     <= in_data.sample;
    end
    if (mem_we) begin
      wr_addr_r <= s1_addr_r;
      wr_new_r  <= s1_sample_r;
      wr_old_r  <= center;
    end
    if (out_load) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  a_phase_only_last_row: assert property (@(posedge clk) disable iff (!rst_n)
    s1_phase_r |-> (s1_valid_r && s1_flags_r.two_out))
    else $error("border phase set outside the last row");

  a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && s1_flags_r.emits && out_valid_r && !out_ready) |-> !in_ready)
    else $error("input taken while the work stage is blocked");

  a_frame_end_is_run_end: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.last_of_frame) |-> out_data_r.last_of_run)
    else $error("frame end without run end");

  a_border_result_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_load && s1_phase_r) |=> (out_valid_r && (out_data_r.sharpened == '0)))
    else $error("last row border result not zero");

endmodule

>>> hdl/shp_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module shp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> hdl/shp_pos.sv
// Raster position counters (column, channel, row) and line store addressing.
// Depends on shp_pkg.
module shp_pos #(
  parameter int MAX_WIDTH    = 1024,
  parameter int MAX_CHANNELS = 4
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  advance,
  input  logic                                  frame_start,
  input  logic [$clog2(MAX_WIDTH+1)-1:0]        w_eff,
  input  logic [shp_pkg::FH_W-1:0]              h_eff,
  input  logic [$clog2(MAX_CHANNELS+1)-1:0]     ch_eff,
  output logic [$clog2(MAX_WIDTH*MAX_CHANNELS)-1:0] addr,
  output logic [$clog2(MAX_WIDTH*MAX_CHANNELS)-1:0] addr_right,
  output logic [((MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1)-1:0] chan,
  output shp_pkg::shp_flags_t                   flags
);
  import shp_pkg::*;

  localparam int CW  = $clog2(MAX_WIDTH + 1);
  localparam int XW  = $clog2(MAX_WIDTH);
  localparam int CNW = $clog2(MAX_CHANNELS + 1);
  localparam int CHW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int AW  = $clog2(MAX_WIDTH * MAX_CHANNELS);
  localparam int PW  = XW + CNW + 1;

  logic [XW-1:0]   col_r, col_nxt, x0;
  logic [CHW-1:0]  chan_r, chan_nxt, c0;
  logic [FH_W-1:0] row_r, row_nxt, r0;
  logic [PW-1:0]   prod, sum_c, sum_r;
  logic [CW-1:0]   w_m1;
  logic [FH_W-1:0] h_m1;
  logic [CNW-1:0]  ch_m1;
  logic [CNW:0]    c_inc;
  logic [CW:0]     x_inc;
  logic [FH_W:0]   r_inc;

  always_comb begin
    // Drop to zero on frame start or when a position lies past its bound
    x0 = (frame_start || ({1'b0, col_r} >= {1'b0, w_eff})) ? '0 : col_r;
    c0 = (frame_start || ({1'b0, chan_r} >= {1'b0, ch_eff})) ? '0 : chan_r;
    r0 = (frame_start || (row_r >= h_eff)) ? '0 : row_r;

    w_m1  = w_eff - 1'b1;
    h_m1  = h_eff - 1'b1;
    ch_m1 = ch_eff - 1'b1;

    prod  = PW'({{CNW{1'b0}}, x0} * {{XW{1'b0}}, ch_eff});
    sum_c = prod + PW'(c0);
    sum_r = sum_c + PW'(ch_eff);
    addr       = sum_c[AW-1:0];
    addr_right = sum_r[AW-1:0];
    chan       = c0;

    flags.emits       = (r0 != '0);
    flags.two_out     = (r0 == h_m1);
    flags.border      = (r0 == FH_W'(1)) || (x0 == '0) || (PW'(x0) == PW'(w_m1));
    flags.has_right   = (PW'(x0) != PW'(w_m1));
    flags.last_sample = (r0 == h_m1) && (PW'(x0) == PW'(w_m1)) &&
                        (PW'(c0) == PW'(ch_m1));

    // Advance channel, then column, then row
    c_inc = (CNW+1)'(c0) + 1'b1;
    x_inc = (CW+1)'(x0) + 1'b1;
    r_inc = {1'b0, r0} + 1'b1;
    chan_nxt = c0;
    col_nxt  = x0;
    row_nxt  = r0;
    if (c_inc >= {1'b0, ch_eff}) begin
      chan_nxt = '0;
      if (x_inc >= {1'b0, w_eff}) begin
        col_nxt = '0;
        row_nxt = (r_inc >= {1'b0, h_eff}) ? '0 : r_inc[FH_W-1:0];
      end else begin
        col_nxt = x_inc[XW-1:0];
      end
    end else begin
      chan_nxt = c_inc[CHW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r  <= '0;
      chan_r <= '0;
      row_r  <= '0;
    end else if (advance) begin
      col_r  <= col_nxt;
      chan_r <= chan_nxt;
      row_r  <= row_nxt;
    end
  end

endmodule

>>> hdl/shp_kernel.sv
// Laplacian sharpen arithmetic: 5*center minus four neighbors, saturated; zero on a border.
// Depends on shp_pkg.
module shp_kernel (
  input  logic [shp_pkg::SAMPLE_W-1:0] center,
  input  logic [shp_pkg::SAMPLE_W-1:0] left,
  input  logic [shp_pkg::SAMPLE_W-1:0] right,
  input  logic [shp_pkg::SAMPLE_W-1:0] up,
  input  logic [shp_pkg::SAMPLE_W-1:0] down,
  input  logic                         border,
  output logic [shp_pkg::SAMPLE_W-1:0] sharpened
);
  import shp_pkg::*;

  logic [11:0] pos_sum;
  logic [11:0] neg_sum;
  logic [11:0] diff;

  always_comb begin
    pos_sum = {2'b00, center, 2'b00} + {4'b0000, center};
    neg_sum = {4'b0000, left} + {4'b0000, right} + {4'b0000, up} + {4'b0000, down};
    diff    = pos_sum - neg_sum;
    if (border || (neg_sum > pos_sum)) begin
      sharpened = '0;
    end else if (diff > 12'd255) begin
      sharpened = '1;
    end else begin
      sharpened = diff[SAMPLE_W-1:0];
    end
  end

endmodule
